### rtl/adv_mdp_pkg.sv
// ============================================================================
// adv_mdp_pkg - shared types and constants
// Request payload types, configuration layout and structure offsets for the
// manufacturer data parser.
// ============================================================================
package adv_mdp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_AD_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COMPANY_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_LENGTH = 2'd2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_AD_TYPE    = 8'hFF;
    localparam logic [15:0] RST_COMPANY_ID = 16'hFFFF;
    localparam logic [7:0]  RST_MIN_LENGTH = 8'd15;

    // Offsets from the structure start (the length byte)
    localparam logic [7:0] CID_LO_OFFSET = 8'd2;
    localparam logic [7:0] CID_HI_OFFSET = 8'd3;
    localparam int VALUE_OFFSET = 4;
    localparam int NUM_VALUES   = 5;

    typedef struct packed {
        logic [7:0]  match_ad_type;
        logic [15:0] match_company_id;
        logic [7:0]  min_struct_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_packet;
        logic [7:0] packet_length;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] heart_rate_raw;
        logic [15:0] skin_temp_raw;
        logic [15:0] ambient_temp_raw;
        logic [15:0] humidity_val;
        logic [15:0] globe_temp_val;
    } out_t;

endpackage

### rtl/adv_manufacturer_data_parser_core.sv
// ============================================================================
// adv_manufacturer_data_parser_core - advertising manufacturer data parser
// Walks the AD structures of an advertising payload streamed one byte per
// request and reports the five 16-bit values of the matching structure.
// ============================================================================
// Payload bytes arrive one per request on the s_ channel; a request with
// first_of_packet set opens a new packet (dropping any open one) and its
// packet_length gives the payload size. Bytes outside a packet are
// swallowed. The block walks the length-type-value structures until a zero
// length or a structure that overruns the packet, and picks the first one
// whose type equals match_ad_type, whose length byte is at least
// min_struct_length and whose bytes 2..3 hold match_company_id (low byte
// first). Bytes 4..13 of that structure are captured as five little-endian
// words. On the packet's last byte one result request leaves on the m_
// channel: found plus the five words, all zero when nothing matched; value
// bytes beyond the packet read as zero. Throughput is one byte per clock:
// the walker updates its state in a single step, so the only limit is the
// result register, and a final byte stalls only while an earlier result
// is still unclaimed. The final byte sits in the input register, and the
// walker output is loaded into the result register when that byte advances.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data;
// the user must write it only while no packet is in flight, which the block
// itself does not enforce. Index 0 is the AD type, 1 the company ID, 2 the
// minimum length, any other index is ignored.
// ============================================================================
module adv_manufacturer_data_parser_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  adv_mdp_pkg::in_t                    s_data,
    // result requests
    output logic                                m_valid,
    input  logic                                m_ready,
    output adv_mdp_pkg::out_t                   m_data,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [adv_mdp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adv_mdp_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    adv_mdp_pkg::cfg_t cfg;

    // match criteria
    adv_mdp_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // datapath: input register -> walker -> result register
    adv_mdp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg     (cfg)
    );

endmodule

### rtl/adv_mdp_cfg.sv
// ============================================================================
// adv_mdp_cfg - configuration registers
// Write-only register file holding the match criteria.
// ============================================================================
module adv_mdp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [adv_mdp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adv_mdp_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output adv_mdp_pkg::cfg_t                   cfg
);

    adv_mdp_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_ad_type     <= adv_mdp_pkg::RST_AD_TYPE;
            cfg_reg.match_company_id  <= adv_mdp_pkg::RST_COMPANY_ID;
            cfg_reg.min_struct_length <= adv_mdp_pkg::RST_MIN_LENGTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                adv_mdp_pkg::CFG_IDX_AD_TYPE:    cfg_reg.match_ad_type     <= cfg_wr_data[7:0];
                adv_mdp_pkg::CFG_IDX_COMPANY_ID: cfg_reg.match_company_id  <= cfg_wr_data;
                adv_mdp_pkg::CFG_IDX_MIN_LENGTH: cfg_reg.min_struct_length <= cfg_wr_data[7:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/adv_mdp_walker.sv
// ============================================================================
// adv_mdp_walker - AD structure walk and capture
// Holds the per-packet parse state, processes one byte per step and forms
// the result on the final byte of a packet.
// ============================================================================
module adv_mdp_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  adv_mdp_pkg::in_t    item,
    input  adv_mdp_pkg::cfg_t   cfg,
    output logic                res_valid,
    output adv_mdp_pkg::out_t   res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_TYPE
    } phase_t;

    // Parse state
    logic        in_packet_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  total_reg;
    logic [7:0]  start_reg;
    logic [7:0]  slen_reg;
    phase_t      phase_reg;
    logic [7:0]  clow_reg;
    logic [15:0] vals_reg [adv_mdp_pkg::NUM_VALUES];
    logic        match_reg;
    logic        cand_valid_reg;
    logic [7:0]  cand_start_reg;
    logic [7:0]  next_len_reg;

    // Step results
    logic        open_pkt;
    logic        active;
    logic        last;
    logic [7:0]  b;
    logic [7:0]  pos_cur;
    logic [7:0]  off;
    logic [7:0]  total_next;
    logic [7:0]  start_next;
    logic [7:0]  slen_next;
    phase_t      phase_next;
    logic [7:0]  clow_next;
    logic [15:0] vals_next [adv_mdp_pkg::NUM_VALUES];
    logic        match_next;
    logic        cand_valid_next;
    logic [7:0]  cand_start_next;
    logic [7:0]  next_len_next;

    always_comb begin
        b        = item.data_byte;
        open_pkt = item.first_of_packet;
        active   = open_pkt || in_packet_reg;

        // a first byte restarts the packet state
        pos_cur         = open_pkt ? 8'd0 : pos_reg;
        total_next      = open_pkt ? item.packet_length : total_reg;
        start_next      = open_pkt ? 8'd0 : start_reg;
        slen_next       = open_pkt ? 8'd0 : slen_reg;
        phase_next      = open_pkt ? PH_LEN : phase_reg;
        clow_next       = open_pkt ? 8'd0 : clow_reg;
        match_next      = open_pkt ? 1'b0 : match_reg;
        cand_valid_next = open_pkt ? 1'b0 : cand_valid_reg;
        cand_start_next = open_pkt ? 8'd0 : cand_start_reg;
        next_len_next   = open_pkt ? 8'd0 : next_len_reg;
        for (int j = 0; j < adv_mdp_pkg::NUM_VALUES; j++) begin
            vals_next[j] = open_pkt ? 16'd0 : vals_reg[j];
        end

        off = pos_cur - cand_start_next;

        // pending candidate: company id bytes
        if (cand_valid_next) begin
            if (off == adv_mdp_pkg::CID_LO_OFFSET) begin
                clow_next = b;
            end else if (off == adv_mdp_pkg::CID_HI_OFFSET) begin
                if ({b, clow_next} == cfg.match_company_id) begin
                    match_next = 1'b1;
                end
                cand_valid_next = 1'b0;
            end
        end

        // value capture, little-endian pairs
        if (match_next) begin
            for (int j = 0; j < adv_mdp_pkg::NUM_VALUES; j++) begin
                if (off == 8'(adv_mdp_pkg::VALUE_OFFSET + 2*j)) begin
                    vals_next[j][7:0] = b;
                end else if (off == 8'(adv_mdp_pkg::VALUE_OFFSET + 2*j + 1)) begin
                    vals_next[j][15:8] = b;
                end
            end
        end

        // structure walk
        if (!match_next) begin
            if (phase_next == PH_LEN && pos_cur == next_len_next) begin
                if (b == 8'd0 || ({1'b0, pos_cur} + {1'b0, b}) >= {1'b0, total_next}) begin
                    phase_next = PH_IDLE;
                end else begin
                    start_next = pos_cur;
                    slen_next  = b;
                    phase_next = PH_TYPE;
                end
            end else if (phase_next == PH_TYPE
                         && {1'b0, pos_cur} == ({1'b0, start_next} + 9'd1)) begin
                if (!cand_valid_next && b == cfg.match_ad_type
                    && slen_next >= cfg.min_struct_length) begin
                    cand_valid_next = 1'b1;
                    cand_start_next = start_next;
                end
                // start + len stays below the packet length, so 8 bits suffice
                next_len_next = 8'({1'b0, start_next} + {1'b0, slen_next} + 9'd1);
                phase_next    = PH_LEN;
            end
        end

        last      = ({1'b0, pos_cur} + 9'd1) >= {1'b0, total_next};
        res_valid = active && last;

        res.found            = match_next;
        res.heart_rate_raw   = match_next ? vals_next[0] : 16'd0;
        res.skin_temp_raw    = match_next ? vals_next[1] : 16'd0;
        res.ambient_temp_raw = match_next ? vals_next[2] : 16'd0;
        res.humidity_val     = match_next ? vals_next[3] : 16'd0;
        res.globe_temp_val   = match_next ? vals_next[4] : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg  <= 1'b0;
            pos_reg        <= 8'd0;
            total_reg      <= 8'd0;
            start_reg      <= 8'd0;
            slen_reg       <= 8'd0;
            phase_reg      <= PH_IDLE;
            clow_reg       <= 8'd0;
            match_reg      <= 1'b0;
            cand_valid_reg <= 1'b0;
            cand_start_reg <= 8'd0;
            next_len_reg   <= 8'd0;
            for (int j = 0; j < adv_mdp_pkg::NUM_VALUES; j++) begin
                vals_reg[j] <= 16'd0;
            end
        end else if (step_en && active) begin
            total_reg      <= total_next;
            start_reg      <= start_next;
            slen_reg       <= slen_next;
            clow_reg       <= clow_next;
            match_reg      <= match_next;
            cand_start_reg <= cand_start_next;
            next_len_reg   <= next_len_next;
            for (int j = 0; j < adv_mdp_pkg::NUM_VALUES; j++) begin
                vals_reg[j] <= vals_next[j];
            end
            if (last) begin
                in_packet_reg  <= 1'b0;
                pos_reg        <= pos_cur;
                phase_reg      <= PH_IDLE;
                cand_valid_reg <= 1'b0;
            end else begin
                in_packet_reg  <= 1'b1;
                pos_reg        <= pos_cur + 8'd1;
                phase_reg      <= phase_next;
                cand_valid_reg <= cand_valid_next;
            end
        end
    end

endmodule

### rtl/adv_mdp_core.sv
// ============================================================================
// adv_mdp_core - input register, walker and result register
// Registers each byte request, steps the walker on it and holds the result
// until the downstream side takes it.
// ============================================================================
module adv_mdp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  adv_mdp_pkg::in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output adv_mdp_pkg::out_t   m_data,
    input  adv_mdp_pkg::cfg_t   cfg
);

    logic              in_valid_reg;
    adv_mdp_pkg::in_t  in_data_reg;
    logic              out_valid_reg;
    adv_mdp_pkg::out_t out_data_reg;

    logic              res_valid;
    adv_mdp_pkg::out_t res;
    logic              out_free;
    logic              advance;

    // a byte that ends no packet never waits on the result register
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_ready  = !in_valid_reg || advance;

    adv_mdp_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (in_data_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### verif/tb.sv
// ============================================================================
// tb - manufacturer data parser testbench
// Streams advertising payloads one byte per request into the parser and
// checks every result request against a cycle-free model of the structure
// walk that is kept inside the bench. Runs through several configurations,
// a short directed set of corner packets, then random packets with noise.
// ============================================================================
module tb;
    import adv_mdp_pkg::*;

    localparam int ITEMS_PER_PHASE = 210;
    localparam int NUM_PHASES      = 7;
    localparam int IDLE_PCT        = 35;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;     // margin after the last report is taken
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [7:0]  DIR_TYPE = 8'hFF;
    localparam logic [15:0] DIR_CID  = 16'h1234;

    typedef enum logic [1:0] {WALK_IDLE, WALK_LEN, WALK_TYPE} walk_e;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    adv_manufacturer_data_parser_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Byte requests waiting to be offered, and the reports they must produce
    in_t  byte_requests[$];
    out_t expected_reports[$];
    logic [7:0] pkt_bytes[$];

    int fail_cnt = 0;
    int cycles   = 0;
    bit calm     = 1'b0;    // no idling on either side while set
    bit hold_go  = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    // Bench copy of the configuration registers
    logic [7:0]  cfg_ad_type = RST_AD_TYPE;
    logic [15:0] cfg_cid     = RST_COMPANY_ID;
    logic [7:0]  cfg_min_len = RST_MIN_LENGTH;

    // Structure walk state
    bit          pkt_open;
    int unsigned byte_pos, pkt_total, st_start, st_len, cand_at, next_len_at;
    walk_e       walk = WALK_IDLE;
    bit          cand_live, matched;
    logic [7:0]  cid_lo;
    logic [15:0] vals[NUM_VALUES];

    // Advances the walk by one accepted byte; queues a report on the last byte
    task automatic parse_byte(input in_t req);
        logic [7:0]  db;
        int unsigned pos, off, k;
        out_t        rep;
        db = req.data_byte;
        if (req.first_of_packet) begin
            pkt_open    = 1'b1;
            byte_pos    = 0;
            pkt_total   = req.packet_length;
            st_start    = 0;
            st_len      = 0;
            walk        = WALK_LEN;
            cid_lo      = '0;
            matched     = 1'b0;
            cand_live   = 1'b0;
            cand_at     = 0;
            next_len_at = 0;
            for (int i = 0; i < NUM_VALUES; i++) vals[i] = '0;
        end else if (!pkt_open) begin
            return;     // stray byte, swallowed
        end
        pos = byte_pos;

        // company id bytes of a pending candidate
        if (cand_live) begin
            off = pos - cand_at;
            if (off == CID_LO_OFFSET) begin
                cid_lo = db;
            end else if (off == CID_HI_OFFSET) begin
                if ({db, cid_lo} == cfg_cid) matched = 1'b1;
                cand_live = 1'b0;
            end
        end

        // value capture, little endian, fixed offsets from the structure start
        if (matched) begin
            off = pos - cand_at;
            if (off >= VALUE_OFFSET && off < VALUE_OFFSET + 2 * NUM_VALUES) begin
                k = (off - VALUE_OFFSET) >> 1;
                if (((off - VALUE_OFFSET) & 1) == 0) vals[k][7:0] = db;
                else vals[k][15:8] = db;
            end
        end

        if (!matched) begin
            if (walk == WALK_LEN && pos == next_len_at) begin
                if (db == 0 || pos + db >= pkt_total) begin
                    walk = WALK_IDLE;
                end else begin
                    st_start = pos;
                    st_len   = db;
                    walk     = WALK_TYPE;
                end
            end else if (walk == WALK_TYPE && pos == st_start + 1) begin
                if (!cand_live && db == cfg_ad_type && st_len >= cfg_min_len) begin
                    cand_live = 1'b1;
                    cand_at   = st_start;
                end
                next_len_at = st_start + st_len + 1;
                walk        = WALK_LEN;
            end
        end

        if (pos + 1 >= pkt_total) begin
            rep.found            = matched;
            rep.heart_rate_raw   = matched ? vals[0] : '0;
            rep.skin_temp_raw    = matched ? vals[1] : '0;
            rep.ambient_temp_raw = matched ? vals[2] : '0;
            rep.humidity_val     = matched ? vals[3] : '0;
            rep.globe_temp_val   = matched ? vals[4] : '0;
            expected_reports.push_back(rep);
            pkt_open  = 1'b0;
            walk      = WALK_IDLE;
            cand_live = 1'b0;
        end else begin
            byte_pos = (pos + 1) & 8'hFF;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: offers queued byte requests, idling at random between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) parse_byte(s_data);
            if (!s_valid || s_ready) begin
                if (byte_requests.size() != 0 &&
                    (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
                    s_data  <= byte_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, so the parser backs up and drops s_ready
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: takes result requests and compares them with the oldest report
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result request with no report pending");
                    fail_cnt++;
                end else begin
                    out_t want;
                    want = expected_reports.pop_front();
                    check_field("found", 16'(want.found), 16'(m_data.found));
                    check_field("heart_rate_raw", want.heart_rate_raw,
                                m_data.heart_rate_raw);
                    check_field("skin_temp_raw", want.skin_temp_raw,
                                m_data.skin_temp_raw);
                    check_field("ambient_temp_raw", want.ambient_temp_raw,
                                m_data.ambient_temp_raw);
                    check_field("humidity_val", want.humidity_val,
                                m_data.humidity_val);
                    check_field("globe_temp_val", want.globe_temp_val,
                                m_data.globe_temp_val);
                end
            end
            m_ready <= (hold_left == 0) && (calm || $urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_IDX_AD_TYPE:    cfg_ad_type = val[7:0];
            CFG_IDX_COMPANY_ID: cfg_cid     = val;
            CFG_IDX_MIN_LENGTH: cfg_min_len = val[7:0];
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] d, input logic f, input logic [7:0] len);
        in_t req;
        req.data_byte       = d;
        req.first_of_packet = f;
        req.packet_length   = len;
        byte_requests.push_back(req);
    endtask

    // Queues pkt_bytes as one packet; only the first carries the length
    task automatic push_packet(input int total);
        for (int i = 0; i < pkt_bytes.size(); i++)
            push_byte(pkt_bytes[i], i == 0,
                      i == 0 ? 8'(total) : 8'($urandom_range(255, 0)));
    endtask

    // Random payload of AD structures, at most one built to match
    task automatic build_packet(output int total);
        int r, sl, hi;
        bit placed;
        logic [7:0]  typ;
        logic [15:0] cid;
        pkt_bytes.delete();
        placed = 1'b0;
        total = ($urandom_range(99, 0) < 4) ? $urandom_range(255, 100)
                                             : $urandom_range(40, 1);
        while (pkt_bytes.size() < total) begin
            r = $urandom_range(99, 0);
            if (r < 3) begin
                pkt_bytes.push_back(8'd0);      // early terminator
            end else if (!placed && r < 45) begin
                sl = (cfg_min_len > 3) ? cfg_min_len : 3;
                if (sl > 254) sl = 254;
                hi = (sl + 4 > 254) ? 254 : sl + 4;
                sl = $urandom_range(hi, sl);
                typ = cfg_ad_type;
                cid = cfg_cid;
                // now and then a near miss on the type or the company id
                if ($urandom_range(9, 0) == 0) typ ^= 8'(1 << $urandom_range(7, 0));
                if ($urandom_range(9, 0) == 0) cid ^= 16'(1 << $urandom_range(15, 0));
                pkt_bytes.push_back(8'(sl));
                pkt_bytes.push_back(typ);
                pkt_bytes.push_back(cid[7:0]);
                pkt_bytes.push_back(cid[15:8]);
                repeat (sl - 3) pkt_bytes.push_back(8'($urandom_range(255, 0)));
                placed = 1'b1;
            end else begin
                sl = $urandom_range(12, 1);
                pkt_bytes.push_back(8'(sl));
                pkt_bytes.push_back(r < 60 ? cfg_ad_type : 8'($urandom_range(255, 0)));
                repeat (sl - 1) pkt_bytes.push_back(8'($urandom_range(255, 0)));
            end
        end
        while (pkt_bytes.size() > total) void'(pkt_bytes.pop_back());
    endtask

    task automatic wait_idle();
        while (byte_requests.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int total, r, n, phase_bytes;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) wait_idle();
            calm = (ph == 2);
            case (ph)
                0: begin
                    write_reg(CFG_IDX_AD_TYPE, DIR_TYPE);
                    write_reg(CFG_IDX_COMPANY_ID, DIR_CID);
                    write_reg(CFG_IDX_MIN_LENGTH, 16'd1);
                end
                1: begin
                    write_reg(CFG_IDX_AD_TYPE, RST_AD_TYPE);
                    write_reg(CFG_IDX_COMPANY_ID, RST_COMPANY_ID);
                    write_reg(CFG_IDX_MIN_LENGTH, RST_MIN_LENGTH);
                end
                2: begin
                    write_reg(CFG_IDX_AD_TYPE, 16'hFF);
                    write_reg(CFG_IDX_COMPANY_ID, 16'($urandom_range(65535, 0)));
                    write_reg(CFG_IDX_MIN_LENGTH, 16'd15);
                end
                3: begin
                    write_reg(CFG_IDX_AD_TYPE, 16'h00);
                    write_reg(CFG_IDX_COMPANY_ID, 16'h0000);
                    write_reg(CFG_IDX_MIN_LENGTH, 16'd0);
                end
                4: begin
                    write_reg(CFG_IDX_AD_TYPE, 16'($urandom_range(255, 0)));
                    write_reg(CFG_IDX_COMPANY_ID, 16'($urandom_range(65535, 0)));
                    write_reg(CFG_IDX_MIN_LENGTH, 16'd255);
                end
                5: begin
                    write_reg(CFG_IDX_AD_TYPE, 16'hFF);
                    write_reg(CFG_IDX_COMPANY_ID, 16'($urandom_range(65535, 0)));
                    write_reg(CFG_IDX_MIN_LENGTH, 16'($urandom_range(20, 0)));
                end
                default: begin
                    write_reg(CFG_IDX_AD_TYPE, 16'($urandom_range(255, 0)));
                    write_reg(CFG_IDX_COMPANY_ID, 16'($urandom_range(65535, 0)));
                    write_reg(CFG_IDX_MIN_LENGTH, 16'($urandom_range(20, 0)));
                end
            endcase

            if (ph == 0) begin
                // zero packet length: first byte is also the last, nothing found
                push_byte(8'h00, 1'b1, 8'd0);
                // stray byte outside any packet
                push_byte(8'hFF, 1'b0, 8'hFF);
                // single-byte packet
                push_byte(8'hFF, 1'b1, 8'd1);
                // packet cut short by the next first byte
                push_byte(8'd10, 1'b1, 8'd10);
                push_byte(8'hFF, 1'b0, 8'h00);
                // match whose values run past the end of the packet
                pkt_bytes = '{8'd3, DIR_TYPE, DIR_CID[7:0], DIR_CID[15:8], 8'hAA, 8'hBB};
                push_packet(6);
                // company id would lie beyond the packet
                pkt_bytes = '{8'd1, DIR_TYPE, DIR_CID[7:0]};
                push_packet(3);
                // short structure: id and values taken from the bytes that follow
                pkt_bytes = '{8'd1, DIR_TYPE, DIR_CID[7:0], DIR_CID[15:8],
                              8'h01, 8'h02, 8'h03, 8'h04};
                push_packet(8);
            end else begin
                phase_bytes = 0;
                while (phase_bytes < ITEMS_PER_PHASE) begin
                    r = $urandom_range(99, 0);
                    build_packet(total);
                    if (r < 8 && pkt_bytes.size() > 1) begin
                        // broken packet: the next first byte drops it
                        n = $urandom_range(pkt_bytes.size() - 1, 1);
                        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
                    end
                    push_packet(total);
                    phase_bytes += pkt_bytes.size();
                    if (r >= 8 && r < 14)
                        repeat ($urandom_range(3, 1))
                            push_byte(8'($urandom_range(255, 0)), 1'b0,
                                      8'($urandom_range(255, 0)));
                    if (r >= 14 && r < 17) begin
                        push_byte(8'($urandom_range(255, 0)), 1'b1, 8'd0);
                        phase_bytes++;
                    end
                end
                if (ph == 3) hold_go = 1'b1;
            end
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
